// File: hdl/sbcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbcd_pkg
// Shared constants, types and CRC-32C helpers for the sampled block digest.
// ----------------------------------------------------------------------------
package sbcd_pkg;

    localparam int unsigned DEFAULT_BLOCK_BYTES    = 4096;
    localparam int unsigned MAX_BLOCK_BYTES        = 131072;
    localparam int unsigned PARTITION_OFFSET_BYTES = 1048576;
    localparam int unsigned GROUP_BYTES            = 134217728;
    localparam logic [31:0] CRC_POLY               = 32'h82F63B78;
    localparam int unsigned ZT_DEPTH =
        $clog2(MAX_BLOCK_BYTES / DEFAULT_BLOCK_BYTES) + 1;

    localparam logic [1:0] OP_RANGE = 2'd0;
    localparam logic [1:0] OP_BEAT  = 2'd1;
    localparam logic [1:0] OP_ZERO  = 2'd2;

    typedef struct packed {
        logic        start;
        logic [63:0] idx;
        logic [17:0] size;
        logic [6:0]  pct;
    } t_lane_req;

    typedef struct packed {
        logic done;
        logic sampled;
    } t_lane_rsp;

    function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] crc_fold(logic [31:0] crc, logic [63:0] word,
                                             logic [3:0] nbytes);
        logic [31:0] c;
        logic [3:0]  n;
        c = crc;
        n = (nbytes > 4'd8) ? 4'd8 : nbytes;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) begin
                c = crc_byte(c, word[8*i +: 8]);
            end
        end
        return c;
    endfunction

    function automatic logic [31:0] gf2_times(logic [31:0][31:0] mat, logic [31:0] vec);
        logic [31:0] s;
        s = '0;
        for (int k = 0; k < 32; k++) begin
            if (vec[k]) begin
                s = s ^ mat[k];
            end
        end
        return s;
    endfunction

    // crc digest of n zero bytes (all-ones start, final inversion), by repeated squaring of the one-byte operator
    function automatic logic [31:0] zero_digest(int unsigned nbytes);
        logic [31:0][31:0] op;
        logic [31:0][31:0] sq;
        logic [31:0]       crc;
        int unsigned       n;
        for (int k = 0; k < 32; k++) begin
            op[k] = crc_byte(32'd1 << k, 8'd0);
        end
        crc = '1;
        n   = nbytes;
        for (int j = 0; j < 32; j++) begin
            if (n[0]) begin
                crc = gf2_times(op, crc);
            end
            for (int k = 0; k < 32; k++) begin
                sq[k] = gf2_times(op, op[k]);
            end
            op = sq;
            n  = n >> 1;
        end
        return ~crc;
    endfunction

    function automatic logic [ZT_DEPTH-1:0][31:0] zero_table();
        logic [ZT_DEPTH-1:0][31:0] t;
        for (int i = 0; i < ZT_DEPTH; i++) begin
            t[i] = zero_digest(DEFAULT_BLOCK_BYTES << i);
        end
        return t;
    endfunction

endpackage
`default_nettype wire

// File: hdl/sbcd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbcd_in_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface sbcd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [63:0] block_index;
    logic [31:0] range_blocks;
    logic [17:0] block_bytes;
    logic        first_beat;
    logic        last_beat;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;

    modport source (output valid, opcode, block_index, range_blocks, block_bytes,
                    first_beat, last_beat, data_word, valid_bytes, input ready);
    modport sink (input valid, opcode, block_index, range_blocks, block_bytes,
                  first_beat, last_beat, data_word, valid_bytes, output ready);
endinterface
`default_nettype wire

// File: hdl/sbcd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbcd_out_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface sbcd_out_if;
    logic        valid;
    logic        ready;
    logic        sampled;
    logic        digest_valid;
    logic [31:0] digest;

    modport source (output valid, sampled, digest_valid, digest, input ready);
    modport sink (input valid, sampled, digest_valid, digest, output ready);
endinterface
`default_nettype wire

// File: hdl/sbcd_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbcd_cfg_if
// Configuration write channel for the sample percentage register.
// ----------------------------------------------------------------------------
interface sbcd_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// File: hdl/sbcd_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbcd_lane
// Sampling decision for one block index: serial divider shared by the
// group size, partition offset and position-in-group steps.
// ----------------------------------------------------------------------------
module sbcd_lane
    import sbcd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_lane_req i_req,
    output t_lane_rsp      o_rsp
);

    typedef enum logic [5:0] {
        L_IDLE = 6'b000001,
        L_DIVG = 6'b000010,
        L_DIVP = 6'b000100,
        L_MOD  = 6'b001000,
        L_MUL  = 6'b010000,
        L_CMP  = 6'b100000
    } t_lstate;

    t_lstate     r_st;
    logic [63:0] r_idx;
    logic [6:0]  r_pct;
    logic [63:0] r_dvd;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic [5:0]  r_cnt;
    logic [31:0] r_ingroup;
    logic [38:0] r_lhs;
    logic [38:0] r_rhs;
    logic        r_done;
    logic        r_samp;

    logic [32:0] n_try;
    logic        n_ge;
    logic [31:0] n_rem;
    logic [63:0] n_dvd;

    // one restoring division step per cycle
    always_comb begin
        n_try = {r_rem, r_dvd[63]};
        n_ge  = n_try >= {1'b0, r_dvs};
        n_rem = n_ge ? 32'(n_try - {1'b0, r_dvs}) : n_try[31:0];
        n_dvd = {r_dvd[62:0], n_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= L_IDLE;
            r_done <= 1'b0;
            r_samp <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                L_IDLE: begin
                    if (i_req.start) begin
                        r_idx <= i_req.idx;
                        r_pct <= i_req.pct;
                        r_cnt <= '0;
                        if (i_req.size == '0) begin
                            r_done <= 1'b1;
                            r_samp <= 1'b0;
                        end else begin
                            r_dvd <= 64'(GROUP_BYTES);
                            r_rem <= '0;
                            r_dvs <= 32'(i_req.size);
                            r_st  <= L_DIVG;
                        end
                    end
                end
                L_DIVG: begin
                    r_cnt <= r_cnt + 6'd1;
                    r_dvd <= n_dvd;
                    r_rem <= n_rem;
                    if (r_cnt == '1) begin
                        r_ingroup <= n_dvd[31:0];
                        r_dvd     <= 64'(PARTITION_OFFSET_BYTES);
                        r_rem     <= '0;
                        r_st      <= L_DIVP;
                    end
                end
                L_DIVP: begin
                    r_cnt <= r_cnt + 6'd1;
                    r_dvd <= n_dvd;
                    r_rem <= n_rem;
                    if (r_cnt == '1) begin
                        if (r_idx <= n_dvd) begin
                            r_done <= 1'b1;
                            r_samp <= 1'b1;
                            r_st   <= L_IDLE;
                        end else if (r_ingroup == '0) begin
                            r_done <= 1'b1;
                            r_samp <= 1'b0;
                            r_st   <= L_IDLE;
                        end else begin
                            r_dvd <= r_idx - n_dvd;
                            r_rem <= '0;
                            r_dvs <= r_ingroup;
                            r_st  <= L_MOD;
                        end
                    end
                end
                L_MOD: begin
                    r_cnt <= r_cnt + 6'd1;
                    r_dvd <= n_dvd;
                    r_rem <= n_rem;
                    if (r_cnt == '1) begin
                        r_st <= L_MUL;
                    end
                end
                L_MUL: begin
                    r_lhs <= 39'(r_rem) * 39'd100;
                    r_rhs <= 39'(r_pct) * 39'(r_ingroup);
                    r_st  <= L_CMP;
                end
                L_CMP: begin
                    r_done <= 1'b1;
                    r_samp <= r_lhs <= r_rhs;
                    r_st   <= L_IDLE;
                end
                default: begin
                    r_st <= L_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.sampled = r_samp;

endmodule
`default_nettype wire

// File: hdl/sampled_block_crc32c_digest.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sampled_block_crc32c_digest
// Sampling decision and CRC-32C digest of storage blocks.
// ----------------------------------------------------------------------------
// i_in carries one transaction per item: range check, data beat or zero
// block. o_out returns at most one result per item; i_cfg writes the
// sample percentage and is always ready (write it only while idle).
// A data beat without first_beat is folded into the CRC (up to 8 bytes) in the
// cycle it is taken; the block stays ready for the next transaction, or,
// when last_beat produces a result, first waits in T_RES for a free output.
// A first beat, range check or zero block runs two decision lanes (first
// and last index of a range) side by side; each lane does up to three
// 64-step serial divisions on its one-bit-per-cycle divider, and the block
// waits in T_WAIT until both lanes are done; size zero skips the divisions.
// Results sit in an output register; a stalled receiver holds it, and the
// block may take the next transaction meanwhile, only waiting to write a
// new result until the previous one is taken.
// Reset clears the accumulator to all ones, the sampled flag and the
// percentage to zero; the zero-block digests are constants.
// ----------------------------------------------------------------------------
module sampled_block_crc32c_digest
    import sbcd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sbcd_in_if.sink   i_in,
    sbcd_cfg_if.sink  i_cfg,
    sbcd_out_if.source o_out
);

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_WAIT = 3'b010,
        T_RES  = 3'b100
    } t_tstate;

    localparam logic [ZT_DEPTH-1:0][31:0] ZT = zero_table();

    t_tstate     r_st;
    logic [6:0]  r_pct;
    logic [31:0] r_crc;
    logic        r_flag;
    logic [1:0]  r_op;
    logic [17:0] r_size;
    logic        r_last;
    logic [31:0] r_dig;
    logic        r_dec;
    logic        r_d0, r_d1, r_s0, r_s1;
    logic        r_ov, r_osamp, r_odv;
    logic [31:0] r_odig;

    t_lane_req   lreq0, lreq1;
    t_lane_rsp   lrsp0, lrsp1;
    logic        accept;
    logic        lanes_go;
    logic [31:0] n_fold;
    logic        all_done, s0, s1;
    logic        zhit;
    logic [31:0] zdig;
    logic        out_free;

    assign i_in.ready  = (r_st == T_IDLE);
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && i_in.ready;
    assign lanes_go    = accept && ((i_in.opcode == OP_RANGE) || (i_in.opcode == OP_ZERO)
                         || ((i_in.opcode == OP_BEAT) && i_in.first_beat));

    always_comb begin
        lreq0.start = lanes_go;
        lreq0.idx   = i_in.block_index;
        lreq0.size  = i_in.block_bytes;
        lreq0.pct   = r_pct;
        lreq1.start = lanes_go;
        lreq1.idx   = (i_in.opcode == OP_RANGE)
                      ? i_in.block_index + 64'(i_in.range_blocks) - 64'd1
                      : i_in.block_index;
        lreq1.size  = i_in.block_bytes;
        lreq1.pct   = r_pct;
    end

    sbcd_lane u_lane0 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(lreq0), .o_rsp(lrsp0));
    sbcd_lane u_lane1 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(lreq1), .o_rsp(lrsp1));

    assign n_fold   = crc_fold(i_in.first_beat ? 32'hFFFFFFFF : r_crc,
                               i_in.data_word, i_in.valid_bytes);
    assign all_done = (r_d0 || lrsp0.done) && (r_d1 || lrsp1.done);
    assign s0       = lrsp0.done ? lrsp0.sampled : r_s0;
    assign s1       = lrsp1.done ? lrsp1.sampled : r_s1;
    assign out_free = !r_ov || o_out.ready;

    always_comb begin
        zhit = 1'b0;
        zdig = '0;
        for (int i = 0; i < ZT_DEPTH; i++) begin
            if (32'(r_size) == (DEFAULT_BLOCK_BYTES << i)) begin
                zhit = 1'b1;
                zdig = ZT[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= T_IDLE;
            r_pct  <= '0;
            r_crc  <= '1;
            r_flag <= 1'b0;
            r_ov   <= 1'b0;
            r_d0   <= 1'b0;
            r_d1   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_pct <= i_cfg.data;
            end
            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                T_IDLE: begin
                    if (accept) begin
                        r_op   <= i_in.opcode;
                        r_size <= i_in.block_bytes;
                        r_last <= i_in.last_beat;
                        r_d0   <= 1'b0;
                        r_d1   <= 1'b0;
                        if (i_in.opcode == OP_BEAT) begin
                            if (i_in.last_beat) begin
                                r_crc <= '1;
                                r_dig <= ~n_fold;
                            end else begin
                                r_crc <= n_fold;
                            end
                        end
                        if (lanes_go) begin
                            r_st <= T_WAIT;
                        end else if ((i_in.opcode == OP_BEAT) && i_in.last_beat) begin
                            r_st <= T_RES;
                        end
                    end
                end
                T_WAIT: begin
                    r_d0 <= r_d0 || lrsp0.done;
                    r_d1 <= r_d1 || lrsp1.done;
                    r_s0 <= s0;
                    r_s1 <= s1;
                    if (all_done) begin
                        r_dec <= s0 || s1;
                        if (r_op == OP_BEAT) begin
                            r_flag <= s0;
                            r_st   <= r_last ? T_RES : T_IDLE;
                        end else begin
                            r_st <= T_RES;
                        end
                    end
                end
                T_RES: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        r_st <= T_IDLE;
                        case (r_op)
                            OP_BEAT: begin
                                r_osamp <= r_flag;
                                r_odv   <= r_flag;
                                r_odig  <= r_flag ? r_dig : '0;
                            end
                            OP_ZERO: begin
                                r_osamp <= r_dec;
                                r_odv   <= r_dec && zhit;
                                r_odig  <= (r_dec && zhit) ? zdig : '0;
                            end
                            default: begin
                                r_osamp <= r_dec;
                                r_odv   <= 1'b0;
                                r_odig  <= '0;
                            end
                        endcase
                    end
                end
                default: begin
                    r_st <= T_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.sampled      = r_osamp;
    assign o_out.digest_valid = r_odv;
    assign o_out.digest       = r_odig;

endmodule
`default_nettype wire

// File: tb/sv/sampled_block_crc32c_digest_test.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// sampled_block_crc32c_digest_test
// Drives range checks, streamed data blocks and zero blocks into the digest
// block under several sample percentages, predicts every result with an
// independent model of the sampling decision and of CRC-32C, and checks the
// results in order, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module sampled_block_crc32c_digest_test;
    import sbcd_pkg::*;

    // opcode with no operation behind it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic        sampled;
        logic        digest_valid;
        logic [31:0] digest;
    } t_digest_rsp;

    class digest_scoreboard;
        logic [6:0]   percent;
        logic [31:0]  crc_run;
        logic         block_flag;
        logic [31:0]  zero_crc [6];
        t_digest_rsp  pending [$];
        int           errors;

        function new();
            logic [31:0] c;
            int unsigned n;
            int unsigned sz;
            percent = '0;
            crc_run = '1;
            block_flag = 1'b0;
            errors = 0;
            c = '1;
            n = 0;
            sz = DEFAULT_BLOCK_BYTES;
            for (int i = 0; i < 6; i++) begin
                while (n < sz) begin
                    c = crc_step(c, 8'd0);
                    n++;
                end
                zero_crc[i] = ~c;
                sz = sz << 1;
            end
        endfunction

        function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
            c = c ^ {24'd0, b};
            repeat (8) c = c[0] ? ((c >> 1) ^ 32'h82F63B78) : (c >> 1);
            return c;
        endfunction

        function logic decide(logic [63:0] idx, logic [17:0] size);
            logic [63:0] per_group;
            logic [63:0] part;
            logic [63:0] rel;
            if (size == 0) return 1'b0;
            per_group = 64'(GROUP_BYTES) / size;
            part = 64'(PARTITION_OFFSET_BYTES) / size;
            if (idx <= part) return 1'b1;
            if (per_group == 0) return 1'b0;
            rel = (idx - part) % per_group;
            return (rel * 100) <= (64'(percent) * per_group);
        endfunction

        function void note_item(logic [1:0] op, logic [63:0] idx, logic [31:0] cnt,
                                logic [17:0] size, logic fb, logic lb,
                                logic [63:0] word, logic [3:0] nb);
            t_digest_rsp r;
            logic [63:0] t;
            int n;
            r = '{1'b0, 1'b0, 32'd0};
            if (op == OP_RANGE) begin
                r.sampled = decide(idx, size) || decide(idx + 64'(cnt) - 64'd1, size);
                pending.push_back(r);
            end else if (op == OP_BEAT) begin
                if (fb) begin
                    crc_run = '1;
                    block_flag = decide(idx, size);
                end
                n = (nb > 8) ? 8 : nb;
                for (int i = 0; i < n; i++) crc_run = crc_step(crc_run, word[8*i +: 8]);
                if (lb) begin
                    r.sampled = block_flag;
                    r.digest_valid = block_flag;
                    r.digest = block_flag ? ~crc_run : 32'd0;
                    crc_run = '1;
                    pending.push_back(r);
                end
            end else if (op == OP_ZERO) begin
                r.sampled = decide(idx, size);
                if (r.sampled) begin
                    t = 64'(DEFAULT_BLOCK_BYTES);
                    for (int i = 0; i < 6; i++) begin
                        if (t == size && !r.digest_valid) begin
                            r.digest_valid = 1'b1;
                            r.digest = zero_crc[i];
                        end
                        t = t << 1;
                    end
                end
                pending.push_back(r);
            end
        endfunction

        function void check_result(logic s, logic dv, logic [31:0] d);
            t_digest_rsp e;
            if (pending.size() == 0) begin
                $error("unexpected result sampled=%0d digest=%h", s, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (s !== e.sampled) begin
                $error("sampled: expected %0d actual %0d", e.sampled, s);
                errors++;
            end
            if (dv !== e.digest_valid) begin
                $error("digest_valid: expected %0d actual %0d", e.digest_valid, dv);
                errors++;
            end
            if (d !== e.digest) begin
                $error("digest: expected %h actual %h", e.digest, d);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   idle_cycles = 0;
    bit   out_stall_on = 1'b1;

    sbcd_in_if  in_ch ();
    sbcd_cfg_if cfg_ch ();
    sbcd_out_if out_ch ();

    digest_scoreboard board = new();

    sampled_block_crc32c_digest dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_out   (out_ch.source)
    );

    always #6 i_clk = ~i_clk;

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls, check on each transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready)
                board.check_result(out_ch.sampled, out_ch.digest_valid, out_ch.digest);
            out_ch.ready <= out_stall_on ? (gap_len() == 0) : 1'b1;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] op, logic [63:0] idx, logic [31:0] cnt,
                             logic [17:0] size, logic fb, logic lb,
                             logic [63:0] word, logic [3:0] nb);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.block_index <= idx;
        in_ch.range_blocks <= cnt;
        in_ch.block_bytes <= size;
        in_ch.first_beat <= fb;
        in_ch.last_beat <= lb;
        in_ch.data_word <= word;
        in_ch.valid_bytes <= nb;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_item(op, idx, cnt, size, fb, lb, word, nb);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (220) @(posedge i_clk);
    endtask

    task automatic write_percent(logic [6:0] p);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= p;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        board.percent = p;
    endtask

    function automatic logic [17:0] pick_size();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 18'(DEFAULT_BLOCK_BYTES << $urandom_range(0, 5));
        if (p < 50) return 18'd0;
        if (p < 60) return 18'(MAX_BLOCK_BYTES);
        if (p < 70) return 18'($urandom_range(1, 600));
        return 18'($urandom_range(1, MAX_BLOCK_BYTES));
    endfunction

    function automatic logic [63:0] pick_index(logic [17:0] size);
        int p;
        p = $urandom_range(0, 99);
        if (p < 15) return 64'($urandom_range(0, 300));
        if (p < 20) return ~64'($urandom_range(0, 3));
        if (p < 70 && size != 0)
            return 64'(PARTITION_OFFSET_BYTES / size) + 64'($urandom_range(0, 70000));
        return {$urandom, $urandom};
    endfunction

    task automatic send_block(logic [17:0] size, logic [63:0] idx, int beats, bit broken);
        logic [3:0] nb;
        for (int b = 0; b < beats; b++) begin
            nb = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
            send_item(OP_BEAT, (b == 0) ? idx : {$urandom, $urandom},
                      32'($urandom), (b == 0) ? size : pick_size(),
                      broken ? 1'($urandom) : (b == 0), (b == beats - 1),
                      {$urandom, $urandom}, nb);
        end
    endtask

    task automatic random_phase(int items);
        int sent;
        logic [17:0] sz;
        sent = 0;
        while (sent < items) begin
            sz = pick_size();
            case ($urandom_range(0, 9))
                0, 1: begin
                    send_item(OP_RANGE, pick_index(sz), $urandom, sz, 1'($urandom),
                              1'($urandom), {$urandom, $urandom}, 4'($urandom));
                    sent++;
                end
                2, 3: begin
                    send_item(OP_ZERO, pick_index(sz), $urandom, sz, 1'($urandom),
                              1'($urandom), {$urandom, $urandom}, 4'($urandom));
                    sent++;
                end
                4: begin
                    send_item(OP_UNUSED, {$urandom, $urandom}, $urandom, sz, 1'($urandom),
                              1'($urandom), {$urandom, $urandom}, 4'($urandom));
                end
                5: begin
                    send_block(sz, pick_index(sz), $urandom_range(1, 6), 1'b1);
                    sent += 3;
                end
                default: begin
                    send_block(sz, pick_index(sz), $urandom_range(1, 8), 1'b0);
                    sent += 4;
                end
            endcase
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_RANGE;
        in_ch.block_index = '0;
        in_ch.range_blocks = 32'd1;
        in_ch.block_bytes = '0;
        in_ch.first_beat = 1'b0;
        in_ch.last_beat = 1'b0;
        in_ch.data_word = '0;
        in_ch.valid_bytes = 4'd8;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset percentage of zero
        send_item(OP_RANGE, 64'd0, 32'd1, 18'd4096, 1'b0, 1'b0, '0, 4'd8);
        send_item(OP_RANGE, 64'd256, 32'd1, 18'd4096, 1'b0, 1'b0, '0, 4'd8);
        send_item(OP_RANGE, 64'd257, 32'd1, 18'd4096, 1'b0, 1'b0, '0, 4'd8);
        send_item(OP_RANGE, 64'd300, 32'd0, 18'd4096, 1'b0, 1'b0, '0, 4'd8);
        send_item(OP_RANGE, '1, 32'hFFFF_FFFF, 18'd512, 1'b0, 1'b0, '0, 4'd8);
        send_item(OP_RANGE, 64'd5, 32'd5, 18'd0, 1'b0, 1'b0, '0, 4'd8);
        send_item(OP_ZERO, 64'd1, 32'd1, 18'd4096, 1'b0, 1'b0, '0, 4'd8);
        send_item(OP_ZERO, 64'd1, 32'd1, 18'd131072, 1'b0, 1'b0, '0, 4'd8);
        send_item(OP_ZERO, 64'd1, 32'd1, 18'd12288, 1'b0, 1'b0, '0, 4'd8);
        send_item(OP_ZERO, 64'd1, 32'd1, 18'd0, 1'b0, 1'b0, '0, 4'd8);
        send_item(OP_ZERO, 64'd1, 32'd1, 18'h3FFFF, 1'b0, 1'b0, '0, 4'd8);
        send_item(OP_BEAT, 64'd0, 32'd1, 18'd4096, 1'b1, 1'b0, '1, 4'd8);
        send_item(OP_BEAT, 64'd0, 32'd1, 18'd4096, 1'b0, 1'b0, 64'h0123456789ABCDEF, 4'd0);
        send_item(OP_BEAT, 64'd0, 32'd1, 18'd4096, 1'b0, 1'b1, 64'h0123456789ABCDEF, 4'd15);
        send_item(OP_BEAT, 64'd10, 32'd1, 18'd4096, 1'b1, 1'b1, '0, 4'd3);
        send_item(OP_BEAT, '1, 32'd1, 18'd4096, 1'b1, 1'b1, '1, 4'd8);
        send_item(OP_UNUSED, '1, '1, '1, 1'b1, 1'b1, '1, 4'd15);
        wait_drained();

        write_percent(7'd100);
        send_item(OP_RANGE, '1, 32'd1, 18'd4096, 1'b0, 1'b0, '0, 4'd8);
        send_item(OP_ZERO, 64'd99999, 32'd1, 18'd65536, 1'b0, 1'b0, '0, 4'd8);
        random_phase(150);
        wait_drained();

        write_percent(7'd127);
        send_item(OP_RANGE, 64'd1000, 32'd1, 18'd4096, 1'b0, 1'b0, '0, 4'd8);
        random_phase(120);
        // sender holds off until every result is back
        wait_drained();
        out_stall_on = 1'b0;
        random_phase(80);
        out_stall_on = 1'b1;
        wait_drained();

        write_percent(7'd37);
        random_phase(150);
        wait_drained();

        write_percent(7'd1);
        random_phase(130);
        wait_drained();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
hdl/sbcd_pkg.sv
hdl/sbcd_in_if.sv
hdl/sbcd_out_if.sv
hdl/sbcd_cfg_if.sv
hdl/sbcd_lane.sv
hdl/sampled_block_crc32c_digest.sv
tb/sv/sampled_block_crc32c_digest_test.sv
